[rtl/ycbcr_half_to_bgr8_crop_core_defines.svh]
// Assertion macros used by the top file of the converter core.
`ifndef YCBCR_HALF_TO_BGR8_CROP_CORE_DEFINES_SVH
`define YCBCR_HALF_TO_BGR8_CROP_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define YB_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define YB_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define YB_ASSERT_IMP(name, ante, cons)
`define YB_ASSERT_NXT(name, ante, cons)
`endif

`endif

[rtl/ybgr_pkg.sv]
package ybgr_pkg;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int HALF_W    = 16;
  localparam int BYTE_W    = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIS_W,
    REG_VIS_H,
    REG_PAD_W,
    REG_PAD_H
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] RST_VIS_W = 13'd1920;
  localparam logic [CFG_W-1:0] RST_VIS_H = 13'd1080;
  localparam logic [CFG_W-1:0] RST_PAD_W = 13'd1920;
  localparam logic [CFG_W-1:0] RST_PAD_H = 13'd1088;

  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic [HALF_W-1:0] luma;
    logic [HALF_W-1:0] cb;
    logic [HALF_W-1:0] cr;
    logic              row_end;
    logic              frame_end;
  } pix_word_t;

  typedef struct packed {
    logic      push;
    pix_word_t word;
  } fifo_wr_t;

  typedef struct packed {
    logic      avail;
    pix_word_t word;
  } fifo_rd_t;

  localparam logic signed [17:0] C_CR_R   = 18'sd103206;
  localparam logic signed [17:0] C_CB_B   = 18'sd121609;
  localparam logic signed [17:0] C_KR     = 18'sd13933;
  localparam logic signed [17:0] C_KB     = 18'sd4732;
  localparam logic signed [17:0] C_INV_KG = 18'sd91633;

endpackage

[rtl/ycbcr_half_to_bgr8_crop_core.sv]
// Throughput: one word per cycle unless in_stall or out_stall holds the
// flow; the front counters and the eight-stage arithmetic pipeline behind
// a four-word queue each advance once per cycle when not stalled.
// Cropped words advance the counters and produce no output.
// Reset (rst_n low, synchronous) restores the default sizes, zeroes the
// counters and empties the queue and pipeline; no clearing pass follows.
`include "ycbcr_half_to_bgr8_crop_core_defines.svh"

module ycbcr_half_to_bgr8_crop_core #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ybgr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ybgr_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ybgr_pkg::HALF_W-1:0]    in_luma_half,
  input  logic [ybgr_pkg::HALF_W-1:0]    in_blue_diff_half,
  input  logic [ybgr_pkg::HALF_W-1:0]    in_red_diff_half,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ybgr_pkg::BYTE_W-1:0]    out_blue_byte,
  output logic [ybgr_pkg::BYTE_W-1:0]    out_green_byte,
  output logic [ybgr_pkg::BYTE_W-1:0]    out_red_byte,
  output logic                           out_row_end,
  output logic                           out_frame_end
);

  ybgr_pkg::fifo_wr_t wr;
  ybgr_pkg::fifo_rd_t rd;
  logic               fifo_full;
  logic               fifo_pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = fifo_full;

  ybgr_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_luma_half     (in_luma_half),
    .in_blue_diff_half(in_blue_diff_half),
    .in_red_diff_half (in_red_diff_half),
    .fifo_full        (fifo_full),
    .wr               (wr)
  );

  ybgr_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .wr   (wr),
    .pop  (fifo_pop),
    .full (fifo_full),
    .rd   (rd)
  );

  ybgr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .rd            (rd),
    .pop           (fifo_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_blue_byte (out_blue_byte),
    .out_green_byte(out_green_byte),
    .out_red_byte  (out_red_byte),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end)
  );

  `YB_ASSERT_IMP(a_frame_implies_row, out_valid && out_frame_end, out_row_end)
  `YB_ASSERT_IMP(a_held_output_no_pop, out_valid && out_stall, !fifo_pop)
  `YB_ASSERT_IMP(a_no_push_when_full, wr.push, !fifo_full)
  `YB_ASSERT_NXT(a_push_makes_avail, wr.push && !fifo_pop, rd.avail)

endmodule

[rtl/ybgr_front.sv]
module ybgr_front #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [ybgr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ybgr_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  input  logic [ybgr_pkg::HALF_W-1:0]    in_luma_half,
  input  logic [ybgr_pkg::HALF_W-1:0]    in_blue_diff_half,
  input  logic [ybgr_pkg::HALF_W-1:0]    in_red_diff_half,
  input  logic                          fifo_full,
  output ybgr_pkg::fifo_wr_t             wr
);

  localparam int DW = $clog2(MAX_DIMENSION + 1);
  localparam int EW = (DW > ybgr_pkg::CFG_W) ? DW : ybgr_pkg::CFG_W;
  localparam int CW = $clog2(MAX_DIMENSION);

  logic [ybgr_pkg::CFG_W-1:0] vis_w_r, vis_h_r, pad_w_r, pad_h_r;
  logic [CW-1:0] col_r, row_r, col_nxt, row_nxt;
  logic [EW-1:0] pw, ph, vw0, vh0, vw, vh, colx, rowx, col_inc, row_inc;
  logic          kept, rend, accept;

  function automatic logic [EW-1:0] fit_dim(input logic [ybgr_pkg::CFG_W-1:0] v);
    logic [EW-1:0] x;
    x = EW'(v);
    if (x == '0) begin
      return EW'(1);
    end else if (x > EW'(MAX_DIMENSION)) begin
      return EW'(MAX_DIMENSION);
    end
    return x;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vis_w_r <= ybgr_pkg::RST_VIS_W;
      vis_h_r <= ybgr_pkg::RST_VIS_H;
      pad_w_r <= ybgr_pkg::RST_PAD_W;
      pad_h_r <= ybgr_pkg::RST_PAD_H;
    end else if (cfg_valid) begin
      unique case (ybgr_pkg::cfg_reg_t'(cfg_index))
        ybgr_pkg::REG_VIS_W: vis_w_r <= cfg_data;
        ybgr_pkg::REG_VIS_H: vis_h_r <= cfg_data;
        ybgr_pkg::REG_PAD_W: pad_w_r <= cfg_data;
        ybgr_pkg::REG_PAD_H: pad_h_r <= cfg_data;
      endcase
    end
  end

  always_comb begin
    pw   = fit_dim(pad_w_r);
    ph   = fit_dim(pad_h_r);
    vw0  = fit_dim(vis_w_r);
    vh0  = fit_dim(vis_h_r);
    vw   = (vw0 > pw) ? pw : vw0;
    vh   = (vh0 > ph) ? ph : vh0;
    colx = EW'(col_r);
    rowx = EW'(row_r);
    kept = (colx < vw) && (rowx < vh);
    rend = (colx == vw - EW'(1));
    col_inc = colx + EW'(1);
    if (col_inc >= pw) begin
      col_nxt = '0;
      row_inc = rowx + EW'(1);
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_inc = rowx;
    end
    row_nxt = (row_inc >= ph) ? '0 : row_inc[CW-1:0];
  end

  assign accept = in_valid && !fifo_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_comb begin
    wr.push           = accept && kept;
    wr.word.luma      = in_luma_half;
    wr.word.cb        = in_blue_diff_half;
    wr.word.cr        = in_red_diff_half;
    wr.word.row_end   = rend;
    wr.word.frame_end = rend && (rowx == vh - EW'(1));
  end

endmodule

[rtl/ybgr_fifo.sv]
module ybgr_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  ybgr_pkg::fifo_wr_t wr,
  input  logic               pop,
  output logic               full,
  output ybgr_pkg::fifo_rd_t rd
);

  localparam int AW = $clog2(ybgr_pkg::FIFO_DEPTH);
  localparam int NW = $clog2(ybgr_pkg::FIFO_DEPTH + 1);

  ybgr_pkg::pix_word_t mem_r [ybgr_pkg::FIFO_DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == NW'(ybgr_pkg::FIFO_DEPTH));
  assign do_push = wr.push && !full;
  assign do_pop  = pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == AW'(ybgr_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    rd_ptr_nxt = (rd_ptr_r == AW'(ybgr_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    cnt_nxt    = cnt_r + NW'(do_push) - NW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr.word;
    end
  end

  always_comb begin
    rd.avail = (cnt_r != '0);
    rd.word  = mem_r[rd_ptr_r];
  end

endmodule

[rtl/ybgr_back.sv]
module ybgr_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ybgr_pkg::fifo_rd_t         rd,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ybgr_pkg::BYTE_W-1:0] out_blue_byte,
  output logic [ybgr_pkg::BYTE_W-1:0] out_green_byte,
  output logic [ybgr_pkg::BYTE_W-1:0] out_red_byte,
  output logic                       out_row_end,
  output logic                       out_frame_end
);

  localparam int QW = 22;
  localparam int PW = 40;
  localparam int RW = 24;
  localparam int GW = 42;
  localparam int VW = 26;
  localparam int NS = 8;

  logic en;

  logic [NS-1:0] vld_r;
  logic [1:0]    flg_r [NS];

  logic signed [QW-1:0] y1_r, cbm1_r, crm1_r, y1_nxt, cbm1_nxt, crm1_nxt;
  logic signed [QW-1:0] y2_r, y3_r, y4_r;
  logic signed [PW-1:0] pr2_r, pb2_r, pr2_nxt, pb2_nxt;
  logic signed [PW-1:0] pr2_rnd, pb2_rnd;
  logic signed [RW-1:0] r3_r, b3_r, r3_nxt, b3_nxt;
  logic signed [PW-1:0] pkr4_r, pkb4_r, pkr4_nxt, pkb4_nxt, pkr4_rnd, pkb4_rnd;
  logic signed [RW-1:0] r4_r, b4_r, r5_r, b5_r, r6_r, b6_r, r7_r, b7_r;
  logic signed [RW-1:0] t5_r, t5_nxt;
  logic signed [GW-1:0] pg6_r, pg6_nxt, pg6_rnd;
  logic signed [VW-1:0] g7_r, g7_nxt;
  logic [ybgr_pkg::BYTE_W-1:0] blue_r, green_r, red_r, blue_nxt, green_nxt, red_nxt;

  function automatic logic signed [QW-1:0] half_q16(input logic [ybgr_pkg::HALF_W-1:0] h);
    logic [4:0]  e;
    logic [9:0]  m;
    logic [31:0] sh;
    logic [20:0] mag;
    e   = h[14:10];
    m   = h[9:0];
    sh  = '0;
    mag = '0;
    if (e == 5'd31) begin
      mag = (m != '0) ? 21'd0 : 21'h100000;
    end else if (e == 5'd0) begin
      mag = 21'(m >> 8);
    end else begin
      if (e >= 5'd9) begin
        sh = {21'b0, 1'b1, m} << (e - 5'd9);
      end else begin
        sh = {21'b0, 1'b1, m} >> (5'd9 - e);
      end
      mag = (sh > 32'h100000) ? 21'h100000 : sh[20:0];
    end
    return h[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic logic [ybgr_pkg::BYTE_W-1:0] to_byte(input logic signed [VW-1:0] v);
    logic [16:0] c;
    logic [24:0] p;
    logic [8:0]  q;
    logic [15:0] rem;
    logic        inc;
    if (v < 0) begin
      c = '0;
    end else if (v > 26'sd65536) begin
      c = 17'h10000;
    end else begin
      c = v[16:0];
    end
    p   = {c, 8'b0} - {8'b0, c};
    q   = p[24:16];
    rem = p[15:0];
    inc = (rem > 16'h8000) || ((rem == 16'h8000) && q[0]);
    return ybgr_pkg::BYTE_W'(q + 9'(inc));
  endfunction

  assign en  = !(vld_r[NS-1] && out_stall);
  assign pop = en && rd.avail;

  always_comb begin
    y1_nxt   = half_q16(rd.word.luma);
    cbm1_nxt = half_q16(rd.word.cb) - 22'sd32768;
    crm1_nxt = half_q16(rd.word.cr) - 22'sd32768;
    pr2_nxt  = PW'(crm1_r) * PW'(ybgr_pkg::C_CR_R);
    pb2_nxt  = PW'(cbm1_r) * PW'(ybgr_pkg::C_CB_B);
    pr2_rnd  = pr2_r + 40'sd32768;
    pb2_rnd  = pb2_r + 40'sd32768;
    r3_nxt   = RW'(y2_r) + pr2_rnd[PW-1:16];
    b3_nxt   = RW'(y2_r) + pb2_rnd[PW-1:16];
    pkr4_nxt = PW'(r3_r) * PW'(ybgr_pkg::C_KR);
    pkb4_nxt = PW'(b3_r) * PW'(ybgr_pkg::C_KB);
    pkr4_rnd = pkr4_r + 40'sd32768;
    pkb4_rnd = pkb4_r + 40'sd32768;
    t5_nxt   = RW'(y4_r) - pkr4_rnd[PW-1:16] - pkb4_rnd[PW-1:16];
    pg6_nxt  = GW'(t5_r) * GW'(ybgr_pkg::C_INV_KG);
    pg6_rnd  = pg6_r + 42'sd32768;
    g7_nxt   = pg6_rnd[GW-1:16];
    blue_nxt  = to_byte(VW'(b7_r));
    green_nxt = to_byte(g7_r);
    red_nxt   = to_byte(VW'(r7_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], rd.avail};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flg_r[0] <= {rd.word.row_end, rd.word.frame_end};
      for (int i = 1; i < NS; i++) begin
        flg_r[i] <= flg_r[i-1];
      end
      y1_r    <= y1_nxt;
      cbm1_r  <= cbm1_nxt;
      crm1_r  <= crm1_nxt;
      y2_r    <= y1_r;
      pr2_r   <= pr2_nxt;
      pb2_r   <= pb2_nxt;
      y3_r    <= y2_r;
      r3_r    <= r3_nxt;
      b3_r    <= b3_nxt;
      y4_r    <= y3_r;
      r4_r    <= r3_r;
      b4_r    <= b3_r;
      pkr4_r  <= pkr4_nxt;
      pkb4_r  <= pkb4_nxt;
      t5_r    <= t5_nxt;
      r5_r    <= r4_r;
      b5_r    <= b4_r;
      pg6_r   <= pg6_nxt;
      r6_r    <= r5_r;
      b6_r    <= b5_r;
      g7_r    <= g7_nxt;
      r7_r    <= r6_r;
      b7_r    <= b6_r;
      blue_r  <= blue_nxt;
      green_r <= green_nxt;
      red_r   <= red_nxt;
    end
  end

  assign out_valid      = vld_r[NS-1];
  assign out_blue_byte  = blue_r;
  assign out_green_byte = green_r;
  assign out_red_byte   = red_r;
  assign out_row_end    = flg_r[NS-1][1];
  assign out_frame_end  = flg_r[NS-1][0];

endmodule

[dv/ybgr_crop_checker.sv]
module ybgr_crop_checker
  import ybgr_pkg::*;
#(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [HALF_W-1:0]    in_luma_half,
  input  logic [HALF_W-1:0]    in_blue_diff_half,
  input  logic [HALF_W-1:0]    in_red_diff_half,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [BYTE_W-1:0]    out_blue_byte,
  input  logic [BYTE_W-1:0]    out_green_byte,
  input  logic [BYTE_W-1:0]    out_red_byte,
  input  logic                 out_row_end,
  input  logic                 out_frame_end,
  input  logic                 drain_done,
  output int                   errors,
  output int                   pending
);

  localparam longint FIX_ONE  = 64'sd65536;
  localparam longint FIX_HALF = 64'sd32768;
  localparam longint FIX_SAT  = 64'sd16 * FIX_ONE;

  typedef struct {
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
    logic              row_end;
    logic              frame_end;
  } bgr_pixel_t;

  bgr_pixel_t       expected_pixels [$];
  logic [CFG_W-1:0] vis_w;
  logic [CFG_W-1:0] vis_h;
  logic [CFG_W-1:0] pad_w;
  logic [CFG_W-1:0] pad_h;
  int unsigned      col_pos;
  int unsigned      row_pos;
  int               words_seen;
  bit               leftover_reported;

  initial begin
    errors = 0;
    pending = 0;
    words_seen = 0;
  end

  function automatic longint half_to_fixed(logic [HALF_W-1:0] h);
    logic [4:0] ex;
    longint     mag;
    ex = h[14:10];
    if (ex == 5'd31) begin
      if (h[9:0] != 10'd0) return 0;
      mag = FIX_SAT;
    end else if (ex == 5'd0) begin
      mag = longint'(h[9:8]);
    end else begin
      mag = longint'({1'b1, h[9:0]});
      if (ex >= 9) mag = mag << (ex - 9);
      else mag = mag >> (9 - ex);
      if (mag > FIX_SAT) mag = FIX_SAT;
    end
    return h[15] ? -mag : mag;
  endfunction

  function automatic longint fix_round(longint x);
    return (x + FIX_HALF) >>> 16;
  endfunction

  function automatic logic [BYTE_W-1:0] fix_to_byte(longint v);
    longint p;
    longint q;
    longint r;
    if (v < 0) v = 0;
    if (v > FIX_ONE) v = FIX_ONE;
    p = v * 255;
    q = p >>> 16;
    r = p & 64'hFFFF;
    if (r > FIX_HALF || (r == FIX_HALF && q[0])) q = q + 1;
    return q[BYTE_W-1:0];
  endfunction

  function automatic int unsigned fit_dim(logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIMENSION) return MAX_DIMENSION;
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch at word %0d: %s got %0d expected %0d", words_seen, what, got, want);
  endtask

  task automatic predict_pixel(logic [HALF_W-1:0] yh, logic [HALF_W-1:0] cbh,
                               logic [HALF_W-1:0] crh);
    int unsigned pw;
    int unsigned ph;
    int unsigned vw;
    int unsigned vh;
    longint      y;
    longint      cb;
    longint      cr;
    longint      r;
    longint      b;
    longint      g;
    bgr_pixel_t  px;
    pw = fit_dim(pad_w);
    ph = fit_dim(pad_h);
    vw = fit_dim(vis_w);
    vh = fit_dim(vis_h);
    if (vw > pw) vw = pw;
    if (vh > ph) vh = ph;
    if (col_pos < vw && row_pos < vh) begin
      y  = half_to_fixed(yh);
      cb = half_to_fixed(cbh);
      cr = half_to_fixed(crh);
      r  = y + fix_round(longint'(C_CR_R) * (cr - FIX_HALF));
      b  = y + fix_round(longint'(C_CB_B) * (cb - FIX_HALF));
      g  = fix_round((y - fix_round(longint'(C_KR) * r) - fix_round(longint'(C_KB) * b))
                     * longint'(C_INV_KG));
      px.blue      = fix_to_byte(b);
      px.green     = fix_to_byte(g);
      px.red       = fix_to_byte(r);
      px.row_end   = (col_pos == vw - 1);
      px.frame_end = px.row_end && (row_pos == vh - 1);
      expected_pixels.push_back(px);
    end
    col_pos++;
    if (col_pos >= pw) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= ph) row_pos = 0;
  endtask

  task automatic check_word();
    bgr_pixel_t want;
    if (expected_pixels.size() == 0) begin
      report_mismatch("word with none expected, blue_byte", out_blue_byte, 0);
      words_seen++;
      return;
    end
    want = expected_pixels.pop_front();
    if (out_blue_byte !== want.blue) report_mismatch("blue_byte", out_blue_byte, want.blue);
    if (out_green_byte !== want.green) report_mismatch("green_byte", out_green_byte, want.green);
    if (out_red_byte !== want.red) report_mismatch("red_byte", out_red_byte, want.red);
    if (out_row_end !== want.row_end) report_mismatch("row_end", out_row_end, want.row_end);
    if (out_frame_end !== want.frame_end) begin
      report_mismatch("frame_end", out_frame_end, want.frame_end);
    end
    words_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      vis_w = RST_VIS_W;
      vis_h = RST_VIS_H;
      pad_w = RST_PAD_W;
      pad_h = RST_PAD_H;
      col_pos = 0;
      row_pos = 0;
      expected_pixels.delete();
      leftover_reported = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_VIS_W: vis_w = cfg_data;
          REG_VIS_H: vis_h = cfg_data;
          REG_PAD_W: pad_w = cfg_data;
          REG_PAD_H: pad_h = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_word();
      if (in_valid && !in_stall) begin
        predict_pixel(in_luma_half, in_blue_diff_half, in_red_diff_half);
      end
      if (drain_done && !leftover_reported) begin
        leftover_reported = 1'b1;
        if (expected_pixels.size() != 0) begin
          report_mismatch("words never produced", 0, expected_pixels.size());
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

[dv/tb_ycbcr_half_to_bgr8_crop_core.sv]
module tb_ycbcr_half_to_bgr8_crop_core;
  import ybgr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int PHASES         = 17;
  localparam int PHASE_WORDS    = 22;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [HALF_W-1:0]    in_luma_half;
  logic [HALF_W-1:0]    in_blue_diff_half;
  logic [HALF_W-1:0]    in_red_diff_half;
  logic                 out_valid;
  logic                 out_stall;
  logic [BYTE_W-1:0]    out_blue_byte;
  logic [BYTE_W-1:0]    out_green_byte;
  logic [BYTE_W-1:0]    out_red_byte;
  logic                 out_row_end;
  logic                 out_frame_end;
  logic                 drain_done;
  int                   errors;
  int                   pending;
  int                   idle_cycles;
  int                   hold_cycles;
  bit                   no_idle;

  logic [HALF_W-1:0] special_half [16] = '{
    16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00, 16'hFE01, 16'h3C00, 16'h3800,
    16'h0001, 16'h03FF, 16'h0400, 16'h7BFF, 16'h4C00, 16'h4C01, 16'hBC00, 16'hFFFF
  };

  ycbcr_half_to_bgr8_crop_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_luma_half     (in_luma_half),
    .in_blue_diff_half(in_blue_diff_half),
    .in_red_diff_half (in_red_diff_half),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_blue_byte    (out_blue_byte),
    .out_green_byte   (out_green_byte),
    .out_red_byte     (out_red_byte),
    .out_row_end      (out_row_end),
    .out_frame_end    (out_frame_end)
  );

  ybgr_crop_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_luma_half     (in_luma_half),
    .in_blue_diff_half(in_blue_diff_half),
    .in_red_diff_half (in_red_diff_half),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_blue_byte    (out_blue_byte),
    .out_green_byte   (out_green_byte),
    .out_red_byte     (out_red_byte),
    .out_row_end      (out_row_end),
    .out_frame_end    (out_frame_end),
    .drain_done       (drain_done),
    .errors           (errors),
    .pending          (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic logic [HALF_W-1:0] rand_half();
    logic [HALF_W-1:0] h;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: h = {1'b0, 5'($urandom_range(10, 14)), 10'($urandom)};
      4: h = {1'($urandom_range(0, 1)), 5'($urandom_range(12, 16)), 10'($urandom)};
      5: h = special_half[$urandom_range(0, 15)];
      default: h = 16'($urandom);
    endcase
    return h;
  endfunction

  function automatic logic [CFG_W-1:0] rand_dim(int hi);
    if ($urandom_range(0, 7) == 0) return CFG_W'($urandom_range(0, 8191));
    return CFG_W'($urandom_range(0, hi));
  endfunction

  task automatic send_pixel(logic [HALF_W-1:0] y, logic [HALF_W-1:0] cb,
                            logic [HALF_W-1:0] cr);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_luma_half      <= y;
    in_blue_diff_half <= cb;
    in_red_diff_half  <= cr;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_dims(logic [CFG_W-1:0] vw, logic [CFG_W-1:0] vh,
                          logic [CFG_W-1:0] pw, logic [CFG_W-1:0] ph);
    cfg_reg_t         regs [4];
    logic [CFG_W-1:0] vals [4];
    regs = '{REG_VIS_W, REG_VIS_H, REG_PAD_W, REG_PAD_H};
    vals = '{vw, vh, pw, ph};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Receiver: a random hold before each word, or a long hold when one is requested.
  initial begin
    int n;
    out_stall = 1'b1;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 14);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    int words;
    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = REG_VIS_W;
    cfg_data          = '0;
    in_valid          = 1'b0;
    in_luma_half      = '0;
    in_blue_diff_half = '0;
    in_red_diff_half  = '0;
    drain_done        = 1'b0;
    hold_cycles       = 0;
    no_idle           = 1'b0;
    idle_cycles       = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int k = 0; k < 16; k++) begin
      send_pixel(special_half[k], special_half[(k + 5) % 16], special_half[(k + 11) % 16]);
    end
    send_pixel(16'h3800, 16'h3800, 16'h3800);
    send_pixel(16'h3C00, 16'h3800, 16'h3800);
    send_pixel(16'h0000, 16'h3800, 16'h3800);
    send_pixel(16'h3C00, 16'h3C00, 16'h3C00);
    in_valid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: set_dims(13'd3, 13'd2, 13'd5, 13'd4);
        1: set_dims(13'd0, 13'd0, 13'd0, 13'd0);
        2: set_dims(13'd8191, 13'd8191, 13'd8191, 13'd2);
        3: set_dims(13'd10, 13'd3, 13'd4, 13'd5);
        4: set_dims(13'd4096, 13'd1, 13'd4097, 13'd1);
        default: set_dims(rand_dim(9), rand_dim(5), rand_dim(12), rand_dim(6));
      endcase
      words = PHASE_WORDS;
      no_idle = (p % 4 == 2);
      if (p == 1) begin
        // Every word is kept here, so a long hold on the output backs up the input.
        no_idle = 1'b1;
        hold_cycles = 200;
        words = 40;
      end
      for (int k = 0; k < words; k++) send_pixel(rand_half(), rand_half(), rand_half());
      in_valid <= 1'b0;
    end
    no_idle = 1'b0;

    wait_idle();
    drain_done <= 1'b1;
    repeat (2) @(negedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/ybgr_pkg.sv
rtl/ybgr_front.sv
rtl/ybgr_fifo.sv
rtl/ybgr_back.sv
rtl/ycbcr_half_to_bgr8_crop_core.sv
dv/ybgr_crop_checker.sv
dv/tb_ycbcr_half_to_bgr8_crop_core.sv
